@@ hdl/lpe_pkg.sv @@
// shared types and constants of the line position estimator
package lpe_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 12;
  localparam int unsigned NUM_CH          = 6;
  localparam int unsigned GROUP_W         = 36;
  localparam int unsigned STEP_W          = 14;
  localparam int unsigned MAG_W           = 14;
  localparam int unsigned POS_W           = 15;
  localparam int unsigned SUM_W           = 11;
  localparam int unsigned NORM_W          = 8;
  localparam int unsigned CFG_IDX_W       = 3;

  // centroid numerator is 2000 * k, k in -2295..2295
  localparam int unsigned K_W             = 13;
  localparam int unsigned KMAG_W          = 12;
  localparam int unsigned NUM_W           = 23;
  localparam int unsigned WEIGHT_STEP     = 2000;

  localparam logic [NORM_W-1:0]  NORM_MAX    = 8'd255;
  localparam logic [MAG_W-1:0]   MAG_MAX     = 14'd10000;
  localparam logic [GROUP_W-1:0] BLACK_RESET = '0;
  localparam logic [GROUP_W-1:0] WHITE_RESET = '1;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 14'd10;

  typedef logic [NORM_W-1:0] lpe_norm_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLACK_LO = 3'd0,
    REG_BLACK_HI = 3'd1,
    REG_WHITE_LO = 3'd2,
    REG_WHITE_HI = 3'd3,
    REG_STEP     = 3'd4
  } lpe_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_NORM = 3'b010,
    ST_DIV  = 3'b100
  } lpe_state_e;

endpackage

@@ hdl/lpe_if.sv @@
// scan and result channel interfaces of the line position estimator
interface lpe_in_if #(
  parameter int unsigned SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_one;
  logic [SAMPLE_BITS-1:0] sample_two;
  logic [SAMPLE_BITS-1:0] sample_three;
  logic [SAMPLE_BITS-1:0] sample_four;
  logic [SAMPLE_BITS-1:0] sample_five;
  logic [SAMPLE_BITS-1:0] sample_six;

  modport source (
    output valid, sample_one, sample_two, sample_three, sample_four, sample_five,
           sample_six,
    input  ready
  );
  modport sink (
    input  valid, sample_one, sample_two, sample_three, sample_four, sample_five,
           sample_six,
    output ready
  );
endinterface

interface lpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] line_position;
  logic [13:0]        position_magnitude;
  logic [13:0]        limited_position;
  logic [10:0]        intensity_sum;
  logic               no_line;

  modport source (
    output valid, line_position, position_magnitude, limited_position,
           intensity_sum, no_line,
    input  ready
  );
  modport sink (
    input  valid, line_position, position_magnitude, limited_position,
           intensity_sum, no_line,
    output ready
  );
endinterface

@@ hdl/lpe_lane.sv @@
// one normalisation lane: clamp and 8-step restoring division to 0..255
module lpe_lane import lpe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic [SAMPLE_BITS-1:0] black_i,
  input  logic [SAMPLE_BITS-1:0] white_i,
  output logic                   busy_o,
  output lpe_norm_t              norm_o
);

  localparam int unsigned RW = SAMPLE_BITS + NORM_W;

  logic [RW-1:0]          rem_q, rem_d;
  logic [RW-1:0]          dsh_q, dsh_d;
  lpe_norm_t              quo_q, quo_d;
  logic [2:0]             cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic [SAMPLE_BITS-1:0] diff_s, diff_d;
  logic                   ge;

  assign diff_s = sample_i - black_i;
  assign diff_d = white_i - black_i;
  assign ge     = (rem_q >= dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      cnt_d = 3'd7;
      quo_d = '0;
      if (white_i <= black_i || sample_i < black_i) begin
        busy_d = 1'b0;
      end else if (sample_i > white_i) begin
        quo_d  = NORM_MAX;
        busy_d = 1'b0;
      end else begin
        // 255 * (s - black) without a multiplier
        rem_d  = (RW'(diff_s) << NORM_W) - RW'(diff_s);
        dsh_d  = RW'(diff_d) << (NORM_W - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dsh_q;
      end
      quo_d = {quo_q[NORM_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 3'd1;
      if (cnt_q == 3'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign norm_o = quo_q;

endmodule

@@ hdl/lpe_merge.sv @@
// merge stage: intensity sum, weighted sum and 14-step centroid division
module lpe_merge import lpe_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  lpe_norm_t               norm_i [NUM_CH],
  output logic                    busy_o,
  output logic signed [POS_W-1:0] pos_o,
  output logic [MAG_W-1:0]        mag_o,
  output logic [SUM_W-1:0]        total_o
);

  localparam int unsigned DW = NUM_W + 1;

  logic signed [K_W-1:0] d_outer, d_mid, d_inner, k;
  logic [KMAG_W-1:0]     kmag;
  logic [NUM_W-1:0]      num;
  logic [SUM_W-1:0]      total_s;

  logic [NUM_W-1:0]      rem_q, rem_d;
  logic [DW-1:0]         dsh_q, dsh_d;
  logic [MAG_W-1:0]      quo_q, quo_d;
  logic [3:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  neg_q, neg_d;
  logic [SUM_W-1:0]      total_q, total_d;
  logic                  ge;

  // weights are 2000 * (-5, -3, -1, 1, 3, 5)
  assign d_outer = $signed(K_W'(norm_i[5])) - $signed(K_W'(norm_i[0]));
  assign d_mid   = $signed(K_W'(norm_i[4])) - $signed(K_W'(norm_i[1]));
  assign d_inner = $signed(K_W'(norm_i[3])) - $signed(K_W'(norm_i[2]));
  assign k       = (d_outer <<< 2) + d_outer + (d_mid <<< 1) + d_mid + d_inner;
  assign kmag    = k[K_W-1] ? KMAG_W'(-k) : KMAG_W'(k);
  assign num     = NUM_W'(kmag) * NUM_W'(WEIGHT_STEP);

  always_comb begin
    total_s = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      total_s = total_s + SUM_W'(norm_i[i]);
    end
  end

  assign ge = (DW'(rem_q) >= dsh_q);

  always_comb begin
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    total_d = total_q;
    if (start_i) begin
      rem_d   = num;
      dsh_d   = DW'(total_s) << (MAG_W - 1);
      quo_d   = '0;
      cnt_d   = 4'(MAG_W - 1);
      busy_d  = 1'b1;
      neg_d   = k[K_W-1];
      total_d = total_s;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - NUM_W'(dsh_q);
      end
      quo_d = {quo_q[MAG_W-2:0], ge};
      dsh_d = dsh_q >> 1;
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    total_q <= total_d;
  end

  // empty scan: divisor is zero, position forced to zero
  assign mag_o   = (total_q == '0) ? '0 : quo_q;
  assign pos_o   = neg_q ? -$signed(POS_W'(mag_o)) : $signed(POS_W'(mag_o));
  assign busy_o  = busy_q;
  assign total_o = total_q;

endmodule

@@ hdl/line_position_estimator_core.sv @@
// top level of the line position estimator: registers, sequencing, limiter
// sequencing: the lanes normalise an accepted scan beat, the merge divider starts once
//   every lane is done, and its result loads when the output register is free
// one scan at a time: the next scan beat is taken only once the result is loaded;
//   pace set by the per-lane 8-step normaliser and the 14-step centroid divider
// reset: asynchronous active-low; calibration and step limit to defaults,
//   limiter value to zero, no result pending
module line_position_estimator_core import lpe_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  lpe_in_if.sink               in_i,
  lpe_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [GROUP_W-1:0]   cfg_wdata_i
);

  // groups hold three packed levels; pad when three levels exceed the group
  localparam int unsigned PADW = (3 * SAMPLE_BITS > GROUP_W) ? 3 * SAMPLE_BITS : GROUP_W;

  // calibration and limiter configuration
  logic [GROUP_W-1:0] black_lo_q, black_hi_q, white_lo_q, white_hi_q;
  logic [STEP_W-1:0]  step_q;

  // sequencing
  lpe_state_e state_q, state_d;
  logic       in_beat, out_load;

  // lanes
  logic [SAMPLE_BITS-1:0] samples  [NUM_CH];
  logic [SAMPLE_BITS-1:0] black_lv [NUM_CH];
  logic [SAMPLE_BITS-1:0] white_lv [NUM_CH];
  lpe_norm_t              norms    [NUM_CH];
  logic [NUM_CH-1:0]      lane_busy;
  logic [PADW-1:0]        blo_pad, bhi_pad, wlo_pad, whi_pad;

  // merge results
  logic                    merge_start, merge_busy;
  logic signed [POS_W-1:0] merge_pos;
  logic [MAG_W-1:0]        merge_mag;
  logic [SUM_W-1:0]        merge_total;

  // limiter
  logic [MAG_W-1:0]   limited_q, limited_d;
  logic signed [15:0] cur_s, tgt_s, lim_s, moved_s;

  // output register
  logic                    out_valid_q;
  logic signed [POS_W-1:0] pos_q;
  logic [MAG_W-1:0]        mag_q;
  logic [SUM_W-1:0]        sum_q;
  logic                    no_line_q;

  // configuration writes: user must issue them only with no scan in flight; unenforced
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      black_lo_q <= BLACK_RESET;
      black_hi_q <= BLACK_RESET;
      white_lo_q <= WHITE_RESET;
      white_hi_q <= WHITE_RESET;
      step_q     <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLACK_LO: black_lo_q <= cfg_wdata_i;
        REG_BLACK_HI: black_hi_q <= cfg_wdata_i;
        REG_WHITE_LO: white_lo_q <= cfg_wdata_i;
        REG_WHITE_HI: white_hi_q <= cfg_wdata_i;
        REG_STEP:     step_q     <= cfg_wdata_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // unpack the per-channel levels, channel 1 lowest in its group
  assign blo_pad = PADW'(black_lo_q);
  assign bhi_pad = PADW'(black_hi_q);
  assign wlo_pad = PADW'(white_lo_q);
  assign whi_pad = PADW'(white_hi_q);

  assign samples[0] = in_i.sample_one;
  assign samples[1] = in_i.sample_two;
  assign samples[2] = in_i.sample_three;
  assign samples[3] = in_i.sample_four;
  assign samples[4] = in_i.sample_five;
  assign samples[5] = in_i.sample_six;

  assign in_beat = in_i.valid && in_i.ready;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    if (g < 3) begin : g_low
      assign black_lv[g] = blo_pad[g*SAMPLE_BITS +: SAMPLE_BITS];
      assign white_lv[g] = wlo_pad[g*SAMPLE_BITS +: SAMPLE_BITS];
    end else begin : g_high
      assign black_lv[g] = bhi_pad[(g-3)*SAMPLE_BITS +: SAMPLE_BITS];
      assign white_lv[g] = whi_pad[(g-3)*SAMPLE_BITS +: SAMPLE_BITS];
    end

    // each lane latches its sample on the input beat
    lpe_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .start_i  (in_beat),
      .sample_i (samples[g]),
      .black_i  (black_lv[g]),
      .white_i  (white_lv[g]),
      .busy_o   (lane_busy[g]),
      .norm_o   (norms[g])
    );
  end

  lpe_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (merge_start),
    .norm_i  (norms),
    .busy_o  (merge_busy),
    .pos_o   (merge_pos),
    .mag_o   (merge_mag),
    .total_o (merge_total)
  );

  // slew limiter toward the centroid magnitude; overshoot lands on target
  assign cur_s = $signed(16'(limited_q));
  assign tgt_s = $signed(16'(merge_mag));
  assign lim_s = $signed(16'(step_q));

  always_comb begin
    moved_s   = cur_s;
    limited_d = merge_mag;
    if (cur_s > tgt_s) begin
      moved_s = cur_s - lim_s;
      if (tgt_s < moved_s) begin
        limited_d = MAG_W'(moved_s);
      end
    end else if (cur_s < tgt_s) begin
      moved_s = cur_s + lim_s;
      if (tgt_s > moved_s) begin
        limited_d = MAG_W'(moved_s);
      end
    end
  end

  // one scan in flight; the result may wait in the output register
  assign in_i.ready  = (state_q == ST_IDLE);
  assign merge_start = (state_q == ST_NORM) && (lane_busy == '0);
  assign out_load    = (state_q == ST_DIV) && !merge_busy && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_beat)     state_d = ST_NORM;
      ST_NORM: if (merge_start) state_d = ST_DIV;
      ST_DIV:  if (out_load)    state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      limited_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        limited_q   <= limited_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      pos_q     <= merge_pos;
      mag_q     <= merge_mag;
      sum_q     <= merge_total;
      no_line_q <= (merge_total == '0);
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.line_position      = pos_q;
  assign out_o.position_magnitude = mag_q;
  assign out_o.limited_position   = limited_q;
  assign out_o.intensity_sum      = sum_q;
  assign out_o.no_line            = no_line_q;

  // while idle no lane or merge division may still be running
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (lane_busy == '0) && !merge_busy)
    else $error("division still running while idle");

  // limiter value never leaves the magnitude range
  a_limited_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limited_q <= MAG_MAX)
    else $error("limited position out of range");

  // an empty scan reports a centred line
  a_no_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && no_line_q |-> (pos_q == '0) && (mag_q == '0))
    else $error("no_line beat with nonzero position");

  // the merge divider starts only once every lane has finished
  a_merge_after_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    merge_start |=> merge_busy && (lane_busy == '0))
    else $error("merge division not started cleanly");

endmodule
